// ----- hw/rtl/kvs_pkg.sv -----
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants for the keyframe vector sampler
// Status codes, register indices, opcodes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam logic [1:0] STATUS_INTERP = 2'd0;
  localparam logic [1:0] STATUS_HOLD   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  localparam logic [1:0] REG_DURATION  = 2'd0;
  localparam logic [1:0] REG_KEY_COUNT = 2'd1;
  localparam logic [1:0] REG_DEFAULT   = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_HOLD_RD,
    ST_PREV_RD,
    ST_PREV_LD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/kvs_ram.sv -----
// ----------------------------------------------------------------------------
// kvs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kvs_divu.sv -----
// ----------------------------------------------------------------------------
// kvs_divu: restoring divider, one quotient bit per cycle
// Shared by the time wrap (remainder) and the fraction (quotient).
// ----------------------------------------------------------------------------
module kvs_divu #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   r_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  assign trial = {r_r[DW-1:0], q_r[NW-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= num;
        r_r    <= '0;
        d_r    <= den;
      end else if (busy_r) begin
        // shift one dividend bit in, subtract where it fits
        if (!diff[DW+1]) begin
          r_r <= diff[DW:0];
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          r_r <= trial;
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign rem  = r_r[DW-1:0];

endmodule

// ----- hw/rtl/keyframe_vector_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_vector_sampler: keyframe table with linear vector interpolation
// Top level: sequencer, key memories, shared divider, one shared multiplier.
// ----------------------------------------------------------------------------
// A write beat (in_op = 0) stores one keyframe. A sample beat wraps the
// time by loop_duration with a serial remainder (skipped when duration is
// 0), scans the key time memory one entry at a time, then for an
// interpolated result fetches the previous key, runs a serial divide for
// the fraction and three multiply-accumulate steps that share one
// multiplier. Busy is high the whole time. The result appears on the
// out_ ports for one cycle marked by out_valid; the receiver cannot stall
// it. Reading a slot below key_count that was never written yields
// undefined values.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler #(
  parameter int MAX_KEYS        = 64,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [1:0]         out_sample_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int FB  = VALUE_FRAC_BITS;
  localparam int NW  = 32 + FB;

  kvs_pkg::state_t state_r, state_nxt;

  logic [31:0] dur_r;
  logic [6:0]  kcnt_r;
  logic [31:0] dflt_r;
  logic [CW-1:0] n_eff;
  assign n_eff = (32'(kcnt_r) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(kcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= 32'd65536;
      kcnt_r <= '0;
      dflt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kvs_pkg::REG_DURATION:  dur_r  <= cfg_data;
        kvs_pkg::REG_KEY_COUNT: kcnt_r <= cfg_data[6:0];
        kvs_pkg::REG_DEFAULT:   dflt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- key memories ----
  logic          accept, wr_en;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   t_rd;
  logic [95:0]   v_rd;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_op == kvs_pkg::OP_WRITE) &&
                  (32'(in_key_index) < 32'(MAX_KEYS));
  assign waddr  = AW'(in_key_index);

  kvs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(in_key_time),
    .raddr(raddr), .rdata(t_rd));
  kvs_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_values (
    .clk(clk), .we(wr_en), .waddr(waddr),
    .wdata({in_value_z, in_value_y, in_value_x}), .raddr(raddr), .rdata(v_rd));

  // ---- shared divider ----
  logic          div_go, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [31:0]   div_den, div_rem;

  kvs_divu #(.NW(NW), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q), .rem(div_rem));

  // ---- datapath registers ----
  logic [31:0]   t_r, t_nxt, t2_r, t2_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [95:0]   v1_r, v1_nxt, v2_r, v2_nxt, res_r, res_nxt;
  logic [FB:0]   frac_r, frac_nxt;
  logic [1:0]    k_r, k_nxt, stat_r, stat_nxt;
  logic [1:0]    mstep_r, mstep_nxt;

  // one shared signed multiplier: 33-bit difference times fraction
  logic signed [32:0]    m_a;
  logic signed [FB+1:0]  m_b;
  logic signed [FB+34:0] prod_r;
  logic signed [FB+34:0] rnd;
  logic signed [31:0]    v1c, v2c;

  always_comb begin
    v1c = '0;
    v2c = '0;
    unique case (k_r)
      2'd0:    begin v1c = v1_r[31:0];  v2c = v2_r[31:0];  end
      2'd1:    begin v1c = v1_r[63:32]; v2c = v2_r[63:32]; end
      default: begin v1c = v1_r[95:64]; v2c = v2_r[95:64]; end
    endcase
    m_a = 33'(v2c) - 33'(v1c);
    m_b = $signed({1'b0, frac_r});
    rnd = (prod_r + (FB+35)'(1 <<< (FB-1))) >>> FB;
  end

  always_ff @(posedge clk) begin
    prod_r <= (FB+35)'(m_a) * (FB+35)'(m_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt; t2_r <= t2_nxt; i_r <= i_nxt;
    v1_r <= v1_nxt; v2_r <= v2_nxt; res_r <= res_nxt; frac_r <= frac_nxt;
    k_r <= k_nxt; stat_r <= stat_nxt; mstep_r <= mstep_nxt;
  end

  logic [31:0] sum;
  assign sum = v1c + rnd[31:0];

  always_comb begin
    state_nxt = state_r;
    t_nxt = t_r; t2_nxt = t2_r; i_nxt = i_r;
    v1_nxt = v1_r; v2_nxt = v2_r; res_nxt = res_r; frac_nxt = frac_r;
    k_nxt = k_r; stat_nxt = stat_r; mstep_nxt = mstep_r;
    raddr = i_r[AW-1:0];
    div_go = 1'b0;
    div_num = {{FB{1'b0}}, in_sample_time};
    div_den = dur_r;
    out_valid = 1'b0;
    unique case (state_r)
      kvs_pkg::ST_IDLE: begin
        if (accept && in_op == kvs_pkg::OP_SAMPLE) begin
          t_nxt = in_sample_time;
          i_nxt = '0;
          if (n_eff == '0) begin
            res_nxt = {dflt_r, dflt_r, dflt_r};
            stat_nxt = kvs_pkg::STATUS_EMPTY;
            state_nxt = kvs_pkg::ST_DONE;
          end else if (dur_r != '0) begin
            div_go = 1'b1;
            state_nxt = kvs_pkg::ST_MOD;
          end else begin
            state_nxt = kvs_pkg::ST_SRCH_RD;
          end
        end
      end
      kvs_pkg::ST_MOD: begin
        if (div_done) begin
          t_nxt = div_rem;
          state_nxt = kvs_pkg::ST_SRCH_RD;
        end
      end
      // issue read of key i, then compare
      kvs_pkg::ST_SRCH_RD: state_nxt = kvs_pkg::ST_SRCH_CHK;
      kvs_pkg::ST_SRCH_CHK: begin
        if (t_rd >= t_r) begin
          t2_nxt = t_rd;
          v2_nxt = v_rd;
          if (i_r == '0) begin
            res_nxt = v_rd;
            stat_nxt = kvs_pkg::STATUS_HOLD;
            state_nxt = kvs_pkg::ST_DONE;
          end else begin
            i_nxt = i_r - 1'b1;
            state_nxt = kvs_pkg::ST_PREV_RD;
          end
        end else if (i_r == n_eff - 1'b1) begin
          res_nxt = v_rd;
          stat_nxt = kvs_pkg::STATUS_HOLD;
          state_nxt = kvs_pkg::ST_DONE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = kvs_pkg::ST_SRCH_RD;
        end
      end
      kvs_pkg::ST_HOLD_RD: state_nxt = kvs_pkg::ST_DONE;
      kvs_pkg::ST_PREV_RD: state_nxt = kvs_pkg::ST_PREV_LD;
      kvs_pkg::ST_PREV_LD: begin
        v1_nxt = v_rd;
        div_go = 1'b1;
        div_num = {t_r - t_rd, {FB{1'b0}}};
        div_den = t2_r - t_rd;
        state_nxt = kvs_pkg::ST_DIV;
      end
      kvs_pkg::ST_DIV: begin
        if (div_done) begin
          frac_nxt = div_q[FB:0];
          k_nxt = '0;
          mstep_nxt = '0;
          state_nxt = kvs_pkg::ST_MUL;
        end
      end
      // alternate: load product, then accumulate component
      kvs_pkg::ST_MUL: begin
        if (mstep_r == 2'd0) begin
          mstep_nxt = 2'd1;
        end else begin
          mstep_nxt = 2'd0;
          unique case (k_r)
            2'd0:    res_nxt[31:0]  = sum;
            2'd1:    res_nxt[63:32] = sum;
            default: res_nxt[95:64] = sum;
          endcase
          if (k_r == 2'd2) begin
            stat_nxt = kvs_pkg::STATUS_INTERP;
            state_nxt = kvs_pkg::ST_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      kvs_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = kvs_pkg::ST_IDLE;
      end
      default: state_nxt = kvs_pkg::ST_IDLE;
    endcase
  end

  assign busy              = (state_r != kvs_pkg::ST_IDLE);
  assign out_x             = res_r[31:0];
  assign out_y             = res_r[63:32];
  assign out_z             = res_r[95:64];
  assign out_sample_status = stat_r;

  // strobe only in the done cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == kvs_pkg::ST_DONE))
    else $error("strobe outside done");
  // every strobe is followed by idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("not idle after result");
  // interpolation fraction never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kvs_pkg::ST_MUL) |-> (frac_r <= (FB+1)'(1 << FB)))
    else $error("fraction above one");

endmodule

// ----- tb/keyframe_vector_sampler_checker.sv -----
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_checker: result predictor and scoreboard
// Mirrors the key table and registers from the observed write beats and
// config writes, computes the expected vector for each sample and compares results.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_op,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic [31:0]        in_sample_time,
  input  logic               out_valid,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic [1:0]         out_sample_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 sample_total,
  output int                 interp_total,
  output int                 hold_total,
  output int                 empty_total
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         status;
  } vec_result_t;

  localparam int NKEYS = 64;

  logic [31:0]        duration_q;
  logic [6:0]         count_q;
  logic signed [31:0] default_q;
  logic [31:0]        key_t [NKEYS];
  logic signed [31:0] key_v [NKEYS][3];
  vec_result_t        expected_vectors [$];

  // Round-half-up blend of two components by a fraction with 16 fractional bits.
  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input longint frac);
    longint diff;
    longint prod;
    diff = longint'(b) - longint'(a);
    prod = diff * frac + 64'sd32768;
    return 32'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic vec_result_t sample_vector(input logic [31:0] stime);
    vec_result_t r;
    int n;
    int i;
    logic [31:0] t;
    longint frac;
    n = (count_q > NKEYS) ? NKEYS : int'(count_q);
    if (n == 0) begin
      r = '{default_q, default_q, default_q, kvs_pkg::STATUS_EMPTY};
      return r;
    end
    t = (duration_q != 0) ? stime % duration_q : stime;
    for (i = 0; i < n; i++) begin
      if (key_t[i] >= t) break;
    end
    if (i == 0 || i == n) begin
      int h;
      h = (i == 0) ? 0 : n - 1;
      r = '{key_v[h][0], key_v[h][1], key_v[h][2], kvs_pkg::STATUS_HOLD};
    end else begin
      frac = longint'({32'd0, t - key_t[i-1]} << 16) / longint'(key_t[i] - key_t[i-1]);
      r.x = blend(key_v[i-1][0], key_v[i][0], frac);
      r.y = blend(key_v[i-1][1], key_v[i][1], frac);
      r.z = blend(key_v[i-1][2], key_v[i][2], frac);
      r.status = kvs_pkg::STATUS_INTERP;
    end
    return r;
  endfunction

  assign pending = expected_vectors.size();

  always @(posedge clk) begin
    vec_result_t exp_v;
    if (!rst_n) begin
      duration_q   <= 32'd65536;
      count_q      <= '0;
      default_q    <= '0;
      fail_count   = 0;
      sample_total = 0;
      interp_total = 0;
      hold_total   = 0;
      empty_total  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kvs_pkg::REG_DURATION:  duration_q <= cfg_data;
          kvs_pkg::REG_KEY_COUNT: count_q    <= cfg_data[6:0];
          kvs_pkg::REG_DEFAULT:   default_q  <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_op == kvs_pkg::OP_WRITE) begin
          key_t[in_key_index]    = in_key_time;
          key_v[in_key_index][0] = in_value_x;
          key_v[in_key_index][1] = in_value_y;
          key_v[in_key_index][2] = in_value_z;
        end else begin
          exp_v = sample_vector(in_sample_time);
          expected_vectors.push_back(exp_v);
          sample_total++;
          case (exp_v.status)
            kvs_pkg::STATUS_INTERP: interp_total++;
            kvs_pkg::STATUS_HOLD:   hold_total++;
            default:                empty_total++;
          endcase
        end
      end
      if (out_valid) begin
        if (expected_vectors.size() == 0) begin
          $display("%0t: unexpected result beat x=%h y=%h z=%h status=%0d",
                   $time, out_x, out_y, out_z, out_sample_status);
          fail_count++;
        end else begin
          exp_v = expected_vectors.pop_front();
          if (out_x !== exp_v.x) begin
            $display("%0t: x mismatch expected %h actual %h", $time, exp_v.x, out_x);
            fail_count++;
          end
          if (out_y !== exp_v.y) begin
            $display("%0t: y mismatch expected %h actual %h", $time, exp_v.y, out_y);
            fail_count++;
          end
          if (out_z !== exp_v.z) begin
            $display("%0t: z mismatch expected %h actual %h", $time, exp_v.z, out_z);
            fail_count++;
          end
          if (out_sample_status !== exp_v.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, exp_v.status, out_sample_status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/keyframe_vector_sampler_tb.sv -----
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_tb: top-level test of the keyframe sampler
// Loads sorted keyframe tables, samples them at random and edge times under
// several duration, count and default settings, with random start gaps.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = kvs_pkg::OP_WRITE;
  logic [5:0]         in_key_index = '0;
  logic [31:0]        in_key_time = '0;
  logic signed [31:0] in_value_x = '0;
  logic signed [31:0] in_value_y = '0;
  logic signed [31:0] in_value_z = '0;
  logic [31:0]        in_sample_time = '0;
  logic               out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         out_sample_status;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = kvs_pkg::REG_DURATION;
  logic [31:0]        cfg_data = '0;

  int fail_count;
  int pending;
  int sample_total;
  int interp_total;
  int hold_total;
  int empty_total;
  int gap_pct = 9;          // percent of cycles the sender holds off
  int beats_sent = 0;
  int written_keys = 0;     // one past the highest slot written since reset

  always #2 clk = ~clk;

  keyframe_vector_sampler i_dut (.*);

  keyframe_vector_sampler_checker i_chk (.*);

  // Drive one beat; hold start until the block takes it. Start stays high
  // for a following beat and drops during an idle gap or a drain.
  task automatic send_beat(input logic op, input logic [5:0] idx, input logic [31:0] kt,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz, input logic [31:0] st);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_key_index   <= idx;
    in_key_time    <= kt;
    in_value_x     <= vx;
    in_value_y     <= vy;
    in_value_z     <= vz;
    in_sample_time <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_key(input int idx, input logic [31:0] kt,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz);
    send_beat(kvs_pkg::OP_WRITE, 6'(idx), kt, vx, vy, vz, $urandom());
    if (idx + 1 > written_keys) written_keys = idx + 1;
  endtask

  task automatic sample_at(input logic [31:0] st);
    send_beat(kvs_pkg::OP_SAMPLE, 6'($urandom()), $urandom(), $urandom(), $urandom(),
              $urandom(), st);
  endtask

  // Drop start, wait for every result, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3, 0))
      0: return 32'h8000_0000 + $urandom_range(3, 0);
      1: return 32'h7FFF_FFFF - $urandom_range(3, 0);
      default: return $urandom();
    endcase
  endfunction

  // Load n keys with ascending times spread below span, random vectors.
  task automatic load_table(input int n, input logic [31:0] span);
    logic [31:0] kt;
    logic [31:0] stride;
    kt = $urandom_range(3, 0);
    stride = (n > 0) ? span / n : 1;
    if (stride == 0) stride = 1;
    for (int i = 0; i < n; i++) begin
      write_key(i, kt, rand_value(), rand_value(), rand_value());
      // Duplicate times now and then exercise equal neighboring keys.
      if ($urandom_range(7, 0) != 0) kt = kt + 1 + ($urandom() % stride);
    end
  endtask

  // One phase: idle config write, table load, then random samples with occasional rewrites of slot 63.
  task automatic run_phase(input logic [31:0] dur, input int n, input int samples,
                           input logic [31:0] span);
    drain();
    write_reg(kvs_pkg::REG_DURATION, dur);
    write_reg(kvs_pkg::REG_KEY_COUNT, 32'(n));
    write_reg(kvs_pkg::REG_DEFAULT, rand_value());
    load_table(n, span);
    for (int s = 0; s < samples; s++) begin
      if ($urandom_range(9, 0) == 0) write_key(63, $urandom(), $urandom(), 0, 0);
      if ($urandom_range(3, 0) == 0) sample_at($urandom_range(span + 8, 0));
      else sample_at($urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table at reset defaults, then edge cases.
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    drain();
    write_reg(kvs_pkg::REG_DEFAULT, 32'h8000_0000);
    sample_at(32'h1234);
    write_key(0, 32'h100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    write_key(1, 32'h300, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    write_key(63, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3);
    drain();
    write_reg(kvs_pkg::REG_KEY_COUNT, 32'd2);
    sample_at(32'h0);        // before the first key
    sample_at(32'h100);      // exactly on the first key
    sample_at(32'h180);      // a quarter of the way between the keys
    sample_at(32'h2FF);
    sample_at(32'h300);      // on the last key
    sample_at(32'h10200);    // wraps to 0x200
    sample_at(32'h400);      // after the last key
    drain();
    write_reg(kvs_pkg::REG_DURATION, 32'h0);   // wrapping off
    sample_at(32'hFFFF_FFFF);
    sample_at(32'h201);
    drain();
    write_reg(kvs_pkg::REG_DURATION, 32'hFFFF_FFFF);
    sample_at(32'hFFFF_FFFF);
    sample_at(32'h1FF);
    drain();
    write_reg(kvs_pkg::REG_DURATION, 32'h1);
    sample_at(32'h5555_5555);
    drain();

    // Random phases; long tables only now and then since scans are slow.
    while (beats_sent < 1550) begin
      if (beats_sent > 1000) gap_pct = 0;
      else if (beats_sent > 500) gap_pct = 87;
      case ($urandom_range(5, 0))
        0: run_phase(32'h0, $urandom_range(64, 1), 25, $urandom());
        1: run_phase(32'hFFFF_FFFF, 64, 20, 32'hFFFF_0000);
        2: run_phase(32'h1, $urandom_range(4, 1), 15, 32'h10);
        3: begin
          drain();
          write_reg(kvs_pkg::REG_KEY_COUNT, 32'd0);
          write_reg(kvs_pkg::REG_DEFAULT, $urandom());
          repeat (5) sample_at($urandom());
        end
        default: run_phase($urandom_range(32'h0010_0000, 2), $urandom_range(8, 1), 30,
                           32'h000F_0000);
      endcase
    end

    // Hold off until every result is back, then one last beat.
    drain();
    sample_at($urandom());
    drain();

    $display("ran %0d beats: %0d samples (%0d interpolated, %0d held, %0d empty)",
             beats_sent, sample_total, interp_total, hold_total, empty_total);
    if (fail_count == 0 && pending == 0) begin
      $display("keyframe_vector_sampler_tb passed");
    end else begin
      $display("keyframe_vector_sampler_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("keyframe_vector_sampler_tb failed");
    $finish;
  end

endmodule
